// File: sv/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg: shared types and constants of the Pareto archive engine
// Command and status codes, the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package pae_pkg;

  localparam int unsigned PaeCapacity = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DIST   = 2'd1,
    CMD_CUT    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DOMINATED = 3'd1,
    ST_FULL      = 3'd2,
    ST_DISTANCE  = 3'd3,
    ST_QDOM      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_CUT       = 3'd6,
    ST_NOTHING   = 3'd7
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the input beat, clear scan flags
    logic scan;     // present slot of the scan is valid at the RAM output
    logic kill;     // clear valid bit of the scanned slot
    logic write;    // write point into the free slot
    logic sel_dim1; // read out the dimension 1 cut candidate
  } pae_ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic covered;  // some archived point covers the input point
    logic any;      // some valid slot was seen
    logic has_free; // a free slot exists after the removals
    logic cand0;
    logic cand1;
  } pae_stat_t;

endpackage

// File: sv/pae_ram.sv
// ----------------------------------------------------------------------------
// pae_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pae_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/pae_datapath.sv
// ----------------------------------------------------------------------------
// pae_datapath: archive storage and per-slot comparison logic
// Holds the shared point and tag RAM, the valid bits and the scan accumulators.
// ----------------------------------------------------------------------------
module pae_datapath #(
  parameter int unsigned Capacity = pae_pkg::PaeCapacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pae_pkg::pae_ctrl_t          ctrl_i,
  input  logic [$clog2(Capacity)-1:0] raddr_i,
  input  logic [$clog2(Capacity)-1:0] saddr_i,
  input  logic signed [31:0]          coord_x_i,
  input  logic signed [31:0]          coord_y_i,
  input  logic signed [31:0]          upper_x_i,
  input  logic signed [31:0]          upper_y_i,
  input  logic [15:0]                 tag_i,
  output pae_pkg::pae_stat_t          stat_o,
  output logic signed [31:0]          point_x_o,
  output logic signed [31:0]          point_y_o,
  output logic [15:0]                 point_tag_o,
  output logic [31:0]                 gap_o
);
  import pae_pkg::*;
  localparam int unsigned AW = $clog2(Capacity);

  logic signed [31:0] x_q, y_q, ux_q, uy_q;
  logic [15:0]        tag_q;
  logic [Capacity-1:0] valid_q;
  logic covered_q, any_q, free_q;
  logic [AW-1:0] free_q_idx;
  logic signed [32:0] best_q;
  logic c0_q, c1_q;
  logic signed [31:0] c0x_q, c0y_q, c1x_q, c1y_q;
  logic [15:0] c0t_q, c1t_q;

  logic [79:0] rdata;
  logic signed [31:0] px, py;
  logic sv_valid;

  pae_ram #(.Width(80), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.write),
    .waddr_i (free_q_idx),
    .wdata_i ({tag_q, y_q, x_q}),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  assign px = rdata[31:0];
  assign py = rdata[63:32];
  assign sv_valid = ctrl_i.scan && valid_q[saddr_i];

  logic covers_in, in_covers;
  logic signed [32:0] gx, gy, part;
  logic in_box, is_d1, is_d0;
  logic better0, better1;
  assign covers_in = (px <= x_q) && (py <= y_q);
  assign in_covers = (x_q <= px) && (y_q <= py);
  assign gx   = 33'(px) - 33'(x_q);
  assign gy   = 33'(py) - 33'(y_q);
  assign part = (gx > gy) ? gx : gy;
  assign in_box = (ux_q > px) && (uy_q > py);
  assign is_d1 = (x_q >= px) && (y_q < py);
  assign is_d0 = (x_q < px) && (y_q >= py);
  assign better0 = !c0_q || (px < c0x_q) || ((px == c0x_q) && (py < c0y_q));
  assign better1 = !c1_q || (py < c1y_q) ||
                   ((py == c1y_q) && ((px < c1x_q) || ((px == c1x_q) && (py < c1y_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      covered_q <= 1'b0;
      any_q     <= 1'b0;
      free_q    <= 1'b0;
      c0_q      <= 1'b0;
      c1_q      <= 1'b0;
    end else if (ctrl_i.load) begin
      covered_q <= 1'b0;
      any_q     <= 1'b0;
      free_q    <= 1'b0;
      c0_q      <= 1'b0;
      c1_q      <= 1'b0;
    end else begin
      if (sv_valid) begin
        any_q <= 1'b1;
        if (covers_in) covered_q <= 1'b1;
        if (in_box && is_d0 && better0) c0_q <= 1'b1;
        if (in_box && is_d1 && better1) c1_q <= 1'b1;
      end
      if (ctrl_i.kill && sv_valid && in_covers) begin
        valid_q[saddr_i] <= 1'b0;
      end
      // Lowest free slot, judged after this slot's possible removal.
      if (ctrl_i.kill && !free_q &&
          (!valid_q[saddr_i] || in_covers)) begin
        free_q <= 1'b1;
      end
      if (ctrl_i.write) valid_q[free_q_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q   <= coord_x_i;
      y_q   <= coord_y_i;
      ux_q  <= upper_x_i;
      uy_q  <= upper_y_i;
      tag_q <= tag_i;
    end
    if (ctrl_i.kill && !free_q && (!valid_q[saddr_i] || (sv_valid && in_covers))) begin
      free_q_idx <= saddr_i;
    end
    if (sv_valid && (!any_q || part < best_q)) best_q <= part;
    if (sv_valid && in_box && is_d0 && better0) begin
      c0x_q <= px; c0y_q <= py; c0t_q <= rdata[79:64];
    end
    if (sv_valid && in_box && is_d1 && better1) begin
      c1x_q <= px; c1y_q <= py; c1t_q <= rdata[79:64];
    end
  end

  assign stat_o.covered  = covered_q;
  assign stat_o.any      = any_q;
  assign stat_o.has_free = free_q;
  assign stat_o.cand0    = c0_q;
  assign stat_o.cand1    = c1_q;

  assign point_x_o   = ctrl_i.sel_dim1 ? c1x_q : c0x_q;
  assign point_y_o   = ctrl_i.sel_dim1 ? c1y_q : c0y_q;
  assign point_tag_o = ctrl_i.sel_dim1 ? c1t_q : c0t_q;
  assign gap_o       = best_q[31:0];
endmodule

// File: sv/pae_ctrl.sv
// ----------------------------------------------------------------------------
// pae_ctrl: sequencer of the Pareto archive engine
// Runs the slot scans, decides the outcome and drives the result register.
// ----------------------------------------------------------------------------
module pae_ctrl #(
  parameter int unsigned Capacity = pae_pkg::PaeCapacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic                        cut_dim_o,
  output logic                        last_o,
  output logic                        res_pt_o,
  output logic                        res_gap_o,
  output pae_pkg::pae_ctrl_t          ctrl_o,
  output logic [$clog2(Capacity)-1:0] raddr_o,
  output logic [$clog2(Capacity)-1:0] saddr_o,
  input  pae_pkg::pae_stat_t          stat_i
);
  import pae_pkg::*;
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN1 = 6'b000010,
    S_SCAN2 = 6'b000100,
    S_DEC   = 6'b001000,
    S_OUT   = 6'b010000,
    S_OUT2  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rv_q;  // read data for slot cnt_q-1 is at the RAM output
  logic          rescan_q;
  logic [2:0] st_q, st_d;
  logic dim_q, dim_d, last_q, last_d, pt_q, pt_d, gp_q, gp_d, ov_q, ov_d;

  wire scanning = (state_q == S_SCAN1) || (state_q == S_SCAN2);

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign raddr_o     = cnt_q[AW-1:0];
  assign saddr_o     = AW'(cnt_q - CW'(1));
  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign cut_dim_o   = dim_q;
  assign last_o      = last_q;
  assign res_pt_o    = pt_q;
  assign res_gap_o   = gp_q;

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.load     = (state_q == S_IDLE) && in_valid_i && in_ready_o;
    ctrl_o.scan     = scanning && rv_q;
    ctrl_o.kill     = (state_q == S_SCAN2) && rv_q;
    ctrl_o.sel_dim1 = dim_q;
    state_d = state_q;
    cnt_d   = cnt_q;
    st_d = st_q; dim_d = dim_q; last_d = last_q; pt_d = pt_q; gp_d = gp_q;
    ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (ctrl_o.load) begin
          cnt_d   = '0;
          state_d = S_SCAN1;
        end
      end
      S_SCAN1, S_SCAN2: begin
        if (cnt_q == CW'(Capacity)) begin
          if (rv_q) state_d = S_DEC;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_DEC: begin
        dim_d = 1'b0; last_d = 1'b1; pt_d = 1'b0; gp_d = 1'b0;
        state_d = S_IDLE;
        ov_d = 1'b1;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (stat_i.covered) st_d = ST_DOMINATED;
            else if (state_q == S_DEC && !stat_i.has_free && rescan_q) st_d = ST_FULL;
            else if (!rescan_q) begin
              ov_d = 1'b0; cnt_d = '0; state_d = S_SCAN2;
            end else begin
              st_d = ST_INSERTED;
              ctrl_o.write = 1'b1;
            end
          end
          CMD_DIST: begin
            if (stat_i.covered) st_d = ST_QDOM;
            else if (!stat_i.any) st_d = ST_EMPTY;
            else begin st_d = ST_DISTANCE; gp_d = 1'b1; end
          end
          CMD_CUT: begin
            if (!stat_i.cand0 && !stat_i.cand1) st_d = ST_NOTHING;
            else begin
              st_d = ST_CUT; pt_d = 1'b1;
              dim_d = !stat_i.cand0;
              last_d = !(stat_i.cand0 && stat_i.cand1);
              if (!last_d) state_d = S_OUT;
            end
          end
          default: st_d = ST_NOTHING;
        endcase
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; dim_d = 1'b1; last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_OUT2: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rv_q     <= 1'b0;
      ov_q     <= 1'b0;
      rescan_q <= 1'b0;
      cmd_q    <= CMD_NONE;
      st_q <= '0; dim_q <= 1'b0; last_q <= 1'b0; pt_q <= 1'b0; gp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= scanning && (cnt_q != CW'(Capacity)) && (state_d == state_q);
      ov_q    <= ov_d;
      st_q <= st_d; dim_q <= dim_d; last_q <= last_d; pt_q <= pt_d; gp_q <= gp_d;
      if (ctrl_o.load) begin
        cmd_q    <= cmd_e'(cmd_i);
        rescan_q <= 1'b0;
      end
      if (state_q == S_SCAN2) rescan_q <= 1'b1;
    end
  end
endmodule

// File: sv/pareto_archive_engine_top.sv
// ----------------------------------------------------------------------------
// pareto_archive_engine_top: archive of mutually nondominated 2-D points
// Insert, distance and cutting-point queries over a tagged Pareto archive.
// ----------------------------------------------------------------------------
// Usage: one input beat carries a command (insert, distance query, cutting
// query), a point or lower bound, an upper bound and a tag. Every command
// answers with one result beat, except a cutting query that finds points in
// both objectives, which answers with two (dimension 0 first); the final
// beat of a command has last_o set.
// Flow: each command reads every archive slot once from the storage RAM
// before its result becomes valid.
// An insert that is not dominated reads the archive a second time to remove
// dominated points and find the lowest free slot before its result becomes
// valid. One command is handled at a time: the next input beat is taken at
// the earliest in the cycle after the last result beat of the previous
// command is taken, and a second cut result becomes valid the cycle after
// the first one is taken.
// Reset clears all valid bits at once, so the archive starts empty with no
// clearing pass. A stalled receiver holds the result beat unchanged and the
// block accepts no new command until the result is taken.
// ----------------------------------------------------------------------------
module pareto_archive_engine_top #(
  parameter int unsigned Capacity = pae_pkg::PaeCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] upper_x_i,
  input  logic signed [31:0] upper_y_i,
  input  logic [15:0]        tag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [15:0]        point_tag_o,
  output logic               cut_dim_o,
  output logic [31:0]        gap_o,
  output logic               last_o
);
  import pae_pkg::*;
  localparam int unsigned AW = $clog2(Capacity);

  pae_ctrl_t ctrl;
  pae_stat_t stat;
  logic [AW-1:0] raddr, saddr;
  logic res_pt, res_gap;
  logic signed [31:0] dp_x, dp_y;
  logic [15:0] dp_tag;
  logic [31:0] dp_gap;

  pae_ctrl #(.Capacity(Capacity)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i,
    .out_valid_o, .out_ready_i, .status_o, .cut_dim_o, .last_o,
    .res_pt_o (res_pt), .res_gap_o (res_gap),
    .ctrl_o (ctrl), .raddr_o (raddr), .saddr_o (saddr), .stat_i (stat)
  );

  pae_datapath #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni, .ctrl_i (ctrl), .raddr_i (raddr), .saddr_i (saddr),
    .coord_x_i, .coord_y_i, .upper_x_i, .upper_y_i, .tag_i,
    .stat_o (stat), .point_x_o (dp_x), .point_y_o (dp_y),
    .point_tag_o (dp_tag), .gap_o (dp_gap)
  );

  assign point_x_o   = res_pt ? dp_x : '0;
  assign point_y_o   = res_pt ? dp_y : '0;
  assign point_tag_o = res_pt ? dp_tag : '0;
  assign gap_o       = res_gap ? dp_gap : '0;
endmodule

// File: sv/pae_checker.sv
// ----------------------------------------------------------------------------
// pae_checker: port-level checks of the Pareto archive engine
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module pae_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] gap_o,
  input logic        last_o
);
  import pae_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

  a_no_accept_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted with result pending");

  a_gap_only_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DISTANCE |-> gap_o == '0)
    else $error("gap nonzero outside distance result");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_CUT |-> last_o)
    else $error("non-cut result without last");
endmodule

bind pareto_archive_engine_top pae_checker u_pae_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .gap_o, .last_o
);
